// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
// expects signals named clock and reset in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define TS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define TS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tstat_pkg.sv =====
// types, constants and the bfloat16 conversion for the tensor statistics block
// no dependencies
package tstat_pkg;

   // field and accumulator widths
   localparam int Q_W        = 24;
   localparam int CNT_W      = 17;
   localparam int SUM_W      = 40;
   localparam int SQ_W       = 48;
   localparam int SQS_W      = 64;
   localparam int WIDE_W     = 80;
   localparam int OPND_W     = 40;
   localparam int ROOT_W     = 32;
   localparam int REM_W      = 33;
   localparam int STEP_W     = 7;

   // step counts of the shared unit
   localparam int DIV_STEPS  = 80;
   localparam int MUL_STEPS  = 40;
   localparam int SQRT_STEPS = 32;

   localparam logic [CNT_W-1:0] COUNT_LIMIT = 17'h10000;

   localparam logic signed [Q_W-1:0] Q_MAX = 24'sh7FFFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 24'sh800000;

   typedef struct packed {
      logic [15:0] weight_bits;
      logic        final_item;
   } req_type;

   typedef struct packed {
      logic signed [Q_W-1:0]    mean_value;
      logic [Q_W-1:0]           std_dev;
      logic signed [Q_W-1:0]    min_value;
      logic signed [Q_W-1:0]    max_value;
      logic [ROOT_W-1:0]        l2_norm;
      logic [CNT_W-1:0]         item_count;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_DIV,
      OP_MUL,
      OP_SQRT
   } op_type;

   // command into the shared unit
   typedef struct packed {
      logic              start;
      op_type            op;
      logic [WIDE_W-1:0] arg_a;
      logic [OPND_W-1:0] arg_b;
      logic [OPND_W-1:0] arg_d;
   } iu_cmd_type;

   // status and results out of the shared unit
   typedef struct packed {
      logic              done;
      logic [WIDE_W-1:0] quo;
      logic [CNT_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } iu_res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC,
      ST_ADDSQ,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_SQR_GO,
      ST_SQR_WAIT,
      ST_QDIV_GO,
      ST_QDIV_WAIT,
      ST_VDIV_GO,
      ST_VDIV_WAIT,
      ST_SD_GO,
      ST_SD_WAIT,
      ST_L2_GO,
      ST_L2_WAIT,
      ST_RESULT
   } state_type;

   // bfloat16 to signed Q8.16, truncated toward zero, saturating
   function automatic logic signed [Q_W-1:0] bf16_to_q816(input logic [15:0] bits);
      logic             neg;
      logic [7:0]       ex;
      logic [7:0]       man;
      logic [Q_W-1:0]   mag;
      neg = bits[15];
      ex  = bits[14:7];
      man = {1'b1, bits[6:0]};
      mag = '0;
      if (ex == 8'd0) begin
         mag = '0;
      end else if (ex >= 8'd134) begin
         mag = '0;
      end else if (ex >= 8'd118) begin
         mag = Q_W'(man) << (ex - 8'd118);
      end else if (ex >= 8'd111) begin
         mag = Q_W'(man >> (8'd118 - ex));
      end else begin
         mag = '0;
      end
      if (ex >= 8'd134) begin
         bf16_to_q816 = neg ? Q_MIN : Q_MAX;
      end else begin
         bf16_to_q816 = neg ? -$signed(mag) : $signed(mag);
      end
   endfunction

endpackage

// ===== rtl/tstat_iter_unit.sv =====
// shared iterative unit: restoring divide, shift-add multiply, digit square root
// one wide adder does the work of every step; depends on tstat_pkg
module tstat_iter_unit import tstat_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  iu_cmd_type cmd,
   output iu_res_type res
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   op_type            op_ff, op_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WIDE_W-1:0] a_ff, a_in;
   logic [OPND_W-1:0] b_ff, b_in;
   logic [REM_W-1:0]  r_ff, r_in;
   logic [OPND_W-1:0] d_ff, d_in;

   logic [WIDE_W-1:0] add_x, add_y;
   logic              add_cin;
   logic [WIDE_W:0]   add_sum;
   logic              ge;

   // operand selection for the shared adder
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_cin = 1'b0;
      case (op_ff)
         OP_DIV: begin
            add_x   = WIDE_W'({r_ff[CNT_W-1:0], a_ff[WIDE_W-1]});
            add_y   = ~WIDE_W'(d_ff[CNT_W-1:0]);
            add_cin = 1'b1;
         end
         OP_MUL: begin
            add_x = {a_ff[WIDE_W-2:0], 1'b0};
            add_y = b_ff[OPND_W-1] ? WIDE_W'(d_ff) : '0;
         end
         OP_SQRT: begin
            add_x   = WIDE_W'({r_ff, a_ff[WIDE_W-1 -: 2]});
            add_y   = ~WIDE_W'({b_ff[ROOT_W-1:0], 2'b01});
            add_cin = 1'b1;
         end
         default: begin
            add_x = '0;
         end
      endcase
      add_sum = {1'b0, add_x} + {1'b0, add_y} + (WIDE_W+1)'(add_cin);
      ge      = add_sum[WIDE_W];
   end

   // load on start, one step per cycle while busy
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         d_in    = cmd.arg_d;
         r_in    = '0;
         case (cmd.op)
            OP_DIV: begin
               a_in    = cmd.arg_a;
               b_in    = '0;
               step_in = STEP_W'(DIV_STEPS - 1);
            end
            OP_MUL: begin
               a_in    = '0;
               b_in    = cmd.arg_b;
               step_in = STEP_W'(MUL_STEPS - 1);
            end
            OP_SQRT: begin
               a_in    = {cmd.arg_a[SQS_W-1:0], (WIDE_W-SQS_W)'(0)};
               b_in    = '0;
               step_in = STEP_W'(SQRT_STEPS - 1);
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            OP_DIV: begin
               a_in = {a_ff[WIDE_W-2:0], ge};
               r_in = ge ? REM_W'(add_sum[CNT_W-1:0]) : REM_W'(add_x[CNT_W-1:0]);
            end
            OP_MUL: begin
               a_in = add_sum[WIDE_W-1:0];
               b_in = {b_ff[OPND_W-2:0], 1'b0};
            end
            OP_SQRT: begin
               a_in = {a_ff[WIDE_W-3:0], 2'b00};
               b_in = {b_ff[OPND_W-2:0], ge};
               r_in = ge ? add_sum[REM_W-1:0] : add_x[REM_W-1:0];
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_DIV;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
      step_ff <= step_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
   end

   assign res.done = done_ff;
   assign res.quo  = a_ff;
   assign res.rem  = r_ff[CNT_W-1:0];
   assign res.root = b_ff[ROOT_W-1:0];

endmodule

// ===== rtl/tensor_statistics_bf16.sv =====
// Streaming statistics over bfloat16 weights: each request carries one weight and a last
// flag; the weight is converted to Q8.16 and folded into count, sum, sum of squares, min
// and max. An ordinary weight goes through accept, square and accumulate. A weight
// flagged last also runs the finalization on the shared iterative unit, one adder step
// per cycle: three 80-step divisions, one 40-step multiply and two 32-step square roots,
// after which one response is presented. req_ready is low while a weight or a
// finalization is in progress. The response sits in an output register, so new
// weights are taken while it waits. Depends on tstat_pkg and tstat_iter_unit.
module tensor_statistics_bf16 import tstat_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type                state_ff, state_in;
   logic signed [Q_W-1:0]    v_ff, v_in;
   logic                     final_ff, final_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQS_W-1:0]         sqs_ff, sqs_in;
   logic signed [Q_W-1:0]    min_ff, min_in;
   logic signed [Q_W-1:0]    max_ff, max_in;
   logic signed [Q_W-1:0]    mean_ff, mean_in;
   logic [Q_W-1:0]           sd_ff, sd_in;
   logic [SQS_W-1:0]         num_ff, num_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   iu_cmd_type               cmd;
   iu_res_type               res;
   logic [SUM_W-1:0]         sum_mag;
   logic signed [SQ_W-1:0]   square;
   logic [Q_W:0]             mean_mag;

   tstat_iter_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (res)
   );

   // magnitude of the running sum and the square of the current weight
   always_comb begin
      sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      square  = v_ff * v_ff;
   end

   // sequencer: accumulation, then finalization on the shared unit
   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      final_in     = final_ff;
      sq_in        = sq_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sqs_in       = sqs_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      mean_in      = mean_ff;
      sd_in        = sd_ff;
      num_in       = num_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      mean_mag     = '0;
      req_ready    = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               v_in     = bf16_to_q816(req_data.weight_bits);
               final_in = req_data.final_item;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            // a weight past the count limit is dropped
            sq_in = '0;
            if (count_ff != COUNT_LIMIT) begin
               sq_in    = SQ_W'(square);
               count_in = count_ff + 1'b1;
               sum_in   = sum_ff + SUM_W'(v_ff);
               if (v_ff < min_ff) begin
                  min_in = v_ff;
               end
               if (v_ff > max_ff) begin
                  max_in = v_ff;
               end
            end
            state_in = ST_ADDSQ;
         end
         ST_ADDSQ: begin
            sqs_in   = sqs_ff + SQS_W'(sq_ff);
            state_in = final_ff ? ST_MEAN_GO : ST_IDLE;
         end
         ST_MEAN_GO: begin
            cmd.start = 1'b1;
            cmd.op    = OP_DIV;
            cmd.arg_a = WIDE_W'(sum_mag);
            cmd.arg_d = OPND_W'(count_ff);
            state_in  = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            // floor division: a negative sum rounds its magnitude up
            mean_mag = {1'b0, res.quo[Q_W-1:0]}
                     + (Q_W+1)'(sum_ff[SUM_W-1] && (res.rem != '0));
            if (res.done) begin
               mean_in  = sum_ff[SUM_W-1] ? -$signed(mean_mag[Q_W-1:0])
                                          : $signed(mean_mag[Q_W-1:0]);
               state_in = ST_SQR_GO;
            end
         end
         ST_SQR_GO: begin
            cmd.start = 1'b1;
            cmd.op    = OP_MUL;
            cmd.arg_b = OPND_W'(sum_mag);
            cmd.arg_d = OPND_W'(sum_mag);
            state_in  = ST_SQR_WAIT;
         end
         ST_SQR_WAIT: begin
            if (res.done) begin
               state_in = ST_QDIV_GO;
            end
         end
         ST_QDIV_GO: begin
            cmd.start = 1'b1;
            cmd.op    = OP_DIV;
            cmd.arg_a = res.quo;
            cmd.arg_d = OPND_W'(count_ff);
            state_in  = ST_QDIV_WAIT;
         end
         ST_QDIV_WAIT: begin
            // variance numerator, zero when negative or overflowing
            if (res.done) begin
               if ((res.quo[WIDE_W-1:SQS_W] == '0) && (res.quo[SQS_W-1:0] <= sqs_ff)) begin
                  num_in = sqs_ff - res.quo[SQS_W-1:0];
               end else begin
                  num_in = '0;
               end
               state_in = ST_VDIV_GO;
            end
         end
         ST_VDIV_GO: begin
            cmd.start = 1'b1;
            cmd.op    = OP_DIV;
            cmd.arg_a = WIDE_W'(num_ff);
            cmd.arg_d = OPND_W'(count_ff);
            state_in  = ST_VDIV_WAIT;
         end
         ST_VDIV_WAIT: begin
            if (res.done) begin
               state_in = ST_SD_GO;
            end
         end
         ST_SD_GO: begin
            cmd.start = 1'b1;
            cmd.op    = OP_SQRT;
            cmd.arg_a = res.quo;
            state_in  = ST_SD_WAIT;
         end
         ST_SD_WAIT: begin
            if (res.done) begin
               sd_in    = (res.root[ROOT_W-1:Q_W] != '0) ? '1 : res.root[Q_W-1:0];
               state_in = ST_L2_GO;
            end
         end
         ST_L2_GO: begin
            cmd.start = 1'b1;
            cmd.op    = OP_SQRT;
            cmd.arg_a = WIDE_W'(sqs_ff);
            state_in  = ST_L2_WAIT;
         end
         ST_L2_WAIT: begin
            if (res.done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // hand over once the output register is free, then restart the stats
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.mean_value = mean_ff;
               rsp_in.std_dev    = sd_ff;
               rsp_in.min_value  = min_ff;
               rsp_in.max_value  = max_ff;
               rsp_in.l2_norm    = res.root;
               rsp_in.item_count = count_ff;
               count_in          = '0;
               sum_in            = '0;
               sqs_in            = '0;
               min_in            = Q_MAX;
               max_in            = Q_MIN;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         sqs_ff       <= '0;
         min_ff       <= Q_MAX;
         max_ff       <= Q_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sqs_ff       <= sqs_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff     <= v_in;
      final_ff <= final_in;
      sq_ff    <= sq_in;
      mean_ff  <= mean_in;
      sd_ff    <= sd_in;
      num_ff   <= num_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/tstat_checker.sv =====
// port-level checks for the tensor statistics block, bound to the top level
// depends on tstat_pkg and assert_macros.svh
`include "assert_macros.svh"

module tstat_checker import tstat_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled response holds
   `TS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")

   // statistics are consistent with one another
   `TS_ASSERT_IMP(a_min_le_max, rsp_valid, $signed(rsp_data.min_value) <= $signed(rsp_data.max_value), "min above max")

   `TS_ASSERT_IMP(a_mean_in_range, rsp_valid, ($signed(rsp_data.mean_value) >= $signed(rsp_data.min_value)) && ($signed(rsp_data.mean_value) <= $signed(rsp_data.max_value)), "mean outside min and max")

   `TS_ASSERT_IMP(a_count_nonzero, rsp_valid, rsp_data.item_count != '0, "response with zero count")

   // a response never appears right after a request is taken
   `TS_ASSERT_NXT(a_no_instant_rsp, req_valid && req_ready, !$rose(rsp_valid), "response right after a request")

endmodule

bind tensor_statistics_bf16 tstat_checker u_checker (.*);
